>>> src/bse_pkg.sv
// Package: shared constants and types for the bucket sort engine.
`default_nettype none
package bse_pkg;
  localparam int MAX_ITEMS   = 64;
  localparam int VALUE_BITS  = 16;
  localparam int CNT_BITS    = $clog2(MAX_ITEMS + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [CNT_BITS-1:0]   count_t;

  typedef struct packed {
    value_t value;
    logic   last;
  } item_t;

  typedef struct packed {
    logic   draining;
    count_t count;
  } sort_status_t;
endpackage
`default_nettype wire

>>> src/bse_queue.sv
// Front: input item queue that decouples acceptance from the sorter.
`default_nettype none
module bse_queue
  import bse_pkg::*;
(
  input  wire   clk,
  input  wire   rst,
  input  wire   push,
  input  item_t wr_item,
  output logic  full,
  output logic  rd_valid,
  input  wire   rd_take,
  output item_t rd_item
);
  item_t                 slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr;
  logic [QPTR_BITS-1:0]  rd_ptr;
  logic [QPTR_BITS:0]    fill;
  logic                  do_wr;
  logic                  do_rd;

  assign full     = (fill == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_item  = slots[rd_ptr];
  assign do_wr    = push && !full;
  assign do_rd    = rd_take && rd_valid;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) fill <= fill + 1'b1;
      else if (do_rd && !do_wr) fill <= fill - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_item;
  end
endmodule
`default_nettype wire

>>> src/bse_sorter.sv
// Back: sorted row of cells fed one item a cycle unless draining; pops head.
`default_nettype none
module bse_sorter
  import bse_pkg::*;
(
  input  wire          clk,
  input  wire          rst,
  input  wire          in_valid,
  input  item_t        in_item,
  output logic         in_take,
  output logic         empty,
  input  wire          pop,
  output value_t       head_value,
  output logic         head_last,
  output sort_status_t status
);
  value_t          cells      [MAX_ITEMS];
  value_t          cells_next [MAX_ITEMS];
  logic            le         [MAX_ITEMS];
  count_t          count;
  logic            draining;
  logic            do_ins;
  logic            do_pop;

  assign in_take    = in_valid && !draining;
  assign do_ins     = in_take && (count < CNT_BITS'(MAX_ITEMS));
  assign do_pop     = pop && draining;
  assign empty      = !draining;
  assign head_value = cells[0];
  assign head_last  = (count == CNT_BITS'(1));
  assign status     = '{draining: draining, count: count};

  // per-cell insert / shift-out selection
  always_comb begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      le[i] = (CNT_BITS'(i) < count) && (cells[i] <= in_item.value);
    end
    for (int i = 0; i < MAX_ITEMS; i++) begin
      cells_next[i] = cells[i];
    end
    if (do_pop) begin
      for (int i = 0; i < MAX_ITEMS - 1; i++) begin
        cells_next[i] = cells[i+1];
      end
    end else if (do_ins) begin
      // cells holding values <= new one stay; the first larger slot takes it
      if (!le[0]) cells_next[0] = in_item.value;
      for (int i = 1; i < MAX_ITEMS; i++) begin
        if (!le[i]) cells_next[i] = le[i-1] ? in_item.value : cells[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ITEMS; i++) cells[i] <= cells_next[i];
  end

  // count and drain control
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      draining <= 1'b0;
    end else if (do_pop) begin
      count <= count - 1'b1;
      if (count == CNT_BITS'(1)) draining <= 1'b0;
    end else if (in_take) begin
      if (do_ins) count <= count + 1'b1;
      if (in_item.last) draining <= 1'b1;
    end
  end
endmodule
`default_nettype wire

>>> src/bucket_sort_engine.sv
// Top level: sorting engine with queue-style input and result channels.
//   channel  | handshake        | fields
//   input    | push / full      | item_value, item_last
//   result   | pop / empty      | sorted_value, sorted_last
// Each item is placed into a sorted row of cells from the 4-entry input
// queue, loading one item per cycle while the row is not draining.
// After the last item, n results drain from the head cell one per cycle
// while pop is high; new items queue up meanwhile and stall (full) once
// the queue fills. Reset (rst, synchronous) empties the queue and the row.
`default_nettype none
module bucket_sort_engine
  import bse_pkg::*;
(
  input  wire          clk,
  input  wire          rst,
  input  wire          push,
  output logic         full,
  input  wire  [15:0]  item_value,
  input  wire          item_last,
  output logic         empty,
  input  wire          pop,
  output logic [15:0]  sorted_value,
  output logic         sorted_last
);
  item_t        wr_item;
  item_t        q_item;
  logic         q_valid;
  logic         q_take;
  value_t       head_value;
  sort_status_t status;

  assign wr_item = '{value: VALUE_BITS'(item_value), last: item_last};

  bse_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .wr_item(wr_item), .full(full),
    .rd_valid(q_valid), .rd_take(q_take), .rd_item(q_item)
  );

  bse_sorter u_sorter (
    .clk(clk), .rst(rst), .in_valid(q_valid), .in_item(q_item),
    .in_take(q_take), .empty(empty), .pop(pop), .head_value(head_value),
    .head_last(sorted_last), .status(status)
  );

  assign sorted_value = 16'(head_value);

`ifndef SYNTHESIS
  a_drain_nonzero: assert property (@(posedge clk) disable iff (rst)
    status.draining |-> status.count != '0) else $error("drain with no items");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && sorted_last) |=> empty) else $error("run not ended");
  a_mid_run: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !sorted_last) |=> !empty) else $error("run ended early");
`endif
endmodule
`default_nettype wire

>>> test/bucket_sort_engine_checker.sv
// Checker: predicts the sorted output of each set and compares every popped item.
`timescale 1ns / 1ps
module bucket_sort_engine_checker
  import bse_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         push,
  input  wire         full,
  input  wire  [15:0] item_value,
  input  wire         item_last,
  input  wire         empty,
  input  wire         pop,
  input  wire  [15:0] sorted_value,
  input  wire         sorted_last,
  output int          fail_count,
  output int          pending,
  output int          sets_sorted,
  output int          items_popped
);
  typedef struct packed {
    value_t value;
    logic   last;
  } sorted_item_t;

  value_t       loaded[$];
  sorted_item_t sorted_due[$];

  task automatic report(input string what);
    $display("MISMATCH t=%0t %s", $time, what);
    fail_count++;
  endtask

  // Sort the loaded set; insertion sort gives the same order as the sorted row.
  task automatic sort_set();
    value_t       row[$];
    value_t       tmp;
    sorted_item_t si;
    int           j;
    row = loaded;
    for (int i = 1; i < row.size(); i++) begin
      j = i;
      while (j > 0 && row[j-1] > row[j]) begin
        tmp = row[j]; row[j] = row[j-1]; row[j-1] = tmp;
        j--;
      end
    end
    foreach (row[k]) begin
      si.value = row[k];
      si.last  = (k == row.size() - 1);
      sorted_due.insert(sorted_due.size(), si);
    end
    loaded.delete();
    sets_sorted++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    sets_sorted = 0;
    items_popped = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      // input side: store full drops the value but a last mark still sorts
      if (push && !full) begin
        if (loaded.size() < MAX_ITEMS) loaded.insert(loaded.size(), item_value);
        if (item_last) sort_set();
      end
      // result side
      if (pop && !empty) begin
        items_popped++;
        if (sorted_due.size() == 0) begin
          report($sformatf("unexpected item %0d", sorted_value));
        end else begin
          if (sorted_value !== sorted_due[0].value)
            report($sformatf("value got %0d want %0d", sorted_value, sorted_due[0].value));
          if (sorted_last !== sorted_due[0].last)
            report($sformatf("last got %b want %b", sorted_last, sorted_due[0].last));
          void'(sorted_due.pop_front());
        end
      end
    end
    pending = sorted_due.size();
  end
endmodule

>>> test/bucket_sort_engine_test.sv
// Testbench top: drives sets of items into the sort engine and gives the verdict.
`timescale 1ns / 1ps
module bucket_sort_engine_test;
  import bse_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [15:0] item_value = '0;
  logic        item_last = 1'b0;
  logic        pop = 1'b0;
  wire         full, empty, sorted_last;
  wire  [15:0] sorted_value;
  int          fail_count, pending, sets_sorted, items_popped;
  int          cycle_count = 0;
  int          items_sent = 0;
  bit          quiet_phase = 1'b0;
  int          pop_idle = 0;

  localparam int CYCLE_LIMIT = 200000;

  always #4 clk = ~clk;

  bucket_sort_engine u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .item_value(item_value), .item_last(item_last),
    .empty(empty), .pop(pop),
    .sorted_value(sorted_value), .sorted_last(sorted_last)
  );

  bucket_sort_engine_checker u_chk (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .item_value(item_value), .item_last(item_last),
    .empty(empty), .pop(pop),
    .sorted_value(sorted_value), .sorted_last(sorted_last),
    .fail_count(fail_count), .pending(pending),
    .sets_sorted(sets_sorted), .items_popped(items_popped)
  );

  // Timeout watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  // Pop side: random stall bursts, none in the quiet phase
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (pop_idle > 0) begin
      pop_idle <= pop_idle - 1;
      pop <= 1'b0;
    end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      pop_idle <= $urandom_range(0, 4);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Offer one item and hold it until accepted
  task automatic send_item(input logic [15:0] v, input logic l);
    int gap;
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item_value <= v;
    item_last <= l;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
  endtask

  // Random set of n items; value style picks small, near-maximum, repeated or full-range values
  task automatic send_set(input int n);
    int          style;
    logic [15:0] v;
    style = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      case (style)
        0: v = 16'($urandom_range(0, 7));
        1: v = 16'($urandom_range(65500, 65535));
        2: v = (i % 3 == 0) ? 16'hFFFF : 16'h0;
        default: v = 16'($urandom);
      endcase
      send_item(v, i == n - 1);
    end
  endtask

  initial begin
    int n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: single item, all zeros, extremes, duplicates
    send_item(16'h1234, 1'b1);
    send_item(16'h0, 1'b0); send_item(16'h0, 1'b0); send_item(16'h0, 1'b1);
    send_item(16'hFFFF, 1'b0); send_item(16'h0, 1'b0); send_item(16'h8000, 1'b0);
    send_item(16'hFFFF, 1'b0); send_item(16'h0001, 1'b1);
    send_item(16'h5, 1'b0); send_item(16'h3, 1'b0); send_item(16'h5, 1'b0);
    send_item(16'h1, 1'b1);
    // Store full: 66 items, the extra ones are dropped, last still sorts
    for (int i = 0; i < 66; i++) send_item(16'($urandom), i == 65);

    // Random sets, mostly small, a few near full size; quiet last part
    while (items_sent < 460) begin
      if (items_sent > 400) quiet_phase = 1'b1;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 64) : $urandom_range(1, 12);
      send_set(n);
    end
    push <= 1'b0;
    item_last <= 1'b0;

    while (pending > 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Sent %0d items in %0d sets; %0d sorted items checked.",
             items_sent, sets_sorted, items_popped);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
